// ===== src/sole_pkg.sv =====
// ----------------------------------------------------------------------------
// sole_pkg: shared types and constants of the SCReLU output layer evaluator
// Queue entry layout, finaliser states, divider status and the fixed scales.
// ----------------------------------------------------------------------------
`default_nettype none

package sole_pkg;

  // Running sum and the wider word that holds it plus two products.
  localparam int SUM_W   = 42;
  localparam int PROD_W  = 33;
  localparam int ACC_W   = 44;

  // Shared divider: numerator width.
  localparam int DIV_W   = 44;

  // 16320 is 255 times 64, so that division first drops six bits.
  localparam int DIV_SHIFT = 6;

  // Finaliser working word, one bit wider than a divider magnitude.
  localparam int FIN_W   = DIV_W + 1;

  localparam int SCORE_W     = 28;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 32;

  localparam logic [7:0] ACT_MAX = 8'd255;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  localparam logic signed [FIN_W-1:0] SCORE_MAX = 45'sd104900000;
  localparam logic signed [FIN_W-1:0] SCORE_MIN = -45'sd104900000;

  typedef struct packed {
    logic [15:0]        sq_mover;
    logic [15:0]        sq_opp;
    logic signed [15:0] w_mover;
    logic signed [15:0] w_opp;
    logic               last;
  } q_entry_t;

  typedef enum logic [2:0] {
    FIN_IDLE,
    FIN_LAUNCH1,
    FIN_DIV1,
    FIN_BIAS,
    FIN_SCALE,
    FIN_LAUNCH2,
    FIN_DIV2,
    FIN_EMIT
  } fin_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ===== src/sole_front.sv =====
// ----------------------------------------------------------------------------
// sole_front: input side of the evaluator
// Picks mover and opponent elements, clamps and squares them, feeds the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sole_front (
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [sole_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                             in_tuser,
  input  wire logic                             in_tlast,
  input  wire logic                             q_full,
  output logic                                  q_push,
  output sole_pkg::q_entry_t                    q_wdata
);
  import sole_pkg::*;

  function automatic logic [7:0] clamp_act(input logic signed [15:0] a);
    logic [7:0] c;
    if (a[15]) begin
      c = 8'd0;
    end else if (|a[14:8]) begin
      c = 8'd255;
    end else begin
      c = a[7:0];
    end
    return c;
  endfunction

  logic signed [15:0] white_acc;
  logic signed [15:0] black_acc;
  logic signed [15:0] mover_acc;
  logic signed [15:0] opp_acc;
  logic [7:0]         act_mover;
  logic [7:0]         act_opp;

  assign white_acc = in_tdata[15:0];
  assign black_acc = in_tdata[31:16];

  // Side to move set means black is the mover.
  assign mover_acc = in_tuser ? black_acc : white_acc;
  assign opp_acc   = in_tuser ? white_acc : black_acc;

  assign act_mover = clamp_act(mover_acc);
  assign act_opp   = clamp_act(opp_acc);

  always_comb begin
    q_wdata.sq_mover = {8'd0, act_mover} * {8'd0, act_mover};
    q_wdata.sq_opp   = {8'd0, act_opp} * {8'd0, act_opp};
    q_wdata.w_mover  = in_tdata[47:32];
    q_wdata.w_opp    = in_tdata[63:48];
    q_wdata.last     = in_tlast;
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

endmodule

`default_nettype wire

// ===== src/sole_fifo.sv =====
// ----------------------------------------------------------------------------
// sole_fifo: short queue between the front and the back
// Register based, one write and one read port, head visible combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module sole_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire sole_pkg::q_entry_t wdata,
  input  wire logic               pop,
  output sole_pkg::q_entry_t      rdata,
  output logic                    full,
  output logic                    empty
);
  import sole_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  q_entry_t        mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata = mem_r[rd_ptr_r];
  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue occupancy beyond its depth");
`endif

endmodule

`default_nettype wire

// ===== src/sole_div.sv =====
// ----------------------------------------------------------------------------
// sole_div: multi-cycle divider by 255 or by 16320
// Folds the numerator in base 256, one fold per cycle, until less than 256 is
// left; shared by both scalings.
// ----------------------------------------------------------------------------
`default_nettype none

module sole_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [sole_pkg::DIV_W-1:0]   num,
  input  wire logic                         by_scale,
  output sole_pkg::div_stat_t               stat,
  output logic [sole_pkg::DIV_W-1:0]        quo
);
  import sole_pkg::*;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [DIV_W-1:0]    rem_r, rem_nxt;
  logic [DIV_W-1:0]    quo_r, quo_nxt;
  logic [DIV_W-1:0]    rem_hi;

  // With the remainder written as 256*hi + lo, 256*hi is 255*hi + hi, so hi
  // moves into the quotient and hi + lo is what is left to divide.
  assign rem_hi = rem_r >> 8;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      rem_nxt  = by_scale ? (num >> DIV_SHIFT) : num;
      quo_nxt  = '0;
    end else if (busy_r) begin
      if (rem_hi != '0) begin
        quo_nxt = quo_r + rem_hi;
        rem_nxt = rem_hi + DIV_W'(rem_r[7:0]);
      end else begin
        // Less than 256 is left; exactly 255 is one more whole divisor.
        if (rem_r[7:0] == ACT_MAX) begin
          quo_nxt = quo_r + DIV_W'(1);
        end
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quo       = quo_r;

endmodule

`default_nettype wire

// ===== src/sole_back.sv =====
// ----------------------------------------------------------------------------
// sole_back: weighting, accumulation and score finaliser
// Multiplies squared activations by weights, keeps the saturating running sum
// and sequences the two divisions, bias, scale and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sole_back (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic signed [15:0]                cfg_wr_data,
  input  wire logic                              q_empty,
  input  wire sole_pkg::q_entry_t                q_rdata,
  output logic                                   q_pop,
  output logic                                   div_start,
  output logic [sole_pkg::DIV_W-1:0]             div_num,
  output logic                                   div_by_scale,
  input  wire sole_pkg::div_stat_t               div_stat,
  input  wire logic [sole_pkg::DIV_W-1:0]        div_quo,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [sole_pkg::OUT_TDATA_W-1:0]       out_tdata
);
  import sole_pkg::*;

  logic                      prod_valid_r, prod_valid_nxt;
  logic                      prod_last_r, prod_last_nxt;
  logic signed [PROD_W-1:0]  prod_m_r, prod_m_nxt;
  logic signed [PROD_W-1:0]  prod_o_r, prod_o_nxt;
  logic signed [SUM_W-1:0]   sum_r, sum_nxt;
  logic signed [ACC_W-1:0]   sum_full;
  logic signed [SUM_W-1:0]   sum_sat;
  fin_state_t                state_r, state_nxt;
  logic signed [FIN_W-1:0]   fin_r, fin_nxt;
  logic                      neg_r, neg_nxt;
  logic signed [15:0]        bias_r, bias_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [SCORE_W-1:0]        out_score_r, out_score_nxt;
  logic                      fin_busy;
  logic                      prod_take;
  logic                      out_load;
  logic signed [FIN_W-1:0]   quo_signed;
  logic signed [FIN_W-1:0]   score_sat;

  // A last item waits in the product stage until the finaliser is free.
  assign fin_busy  = (state_r != FIN_IDLE);
  assign prod_take = prod_valid_r && !(prod_last_r && fin_busy);
  assign q_pop     = !q_empty && (!prod_valid_r || prod_take);

  always_comb begin
    prod_valid_nxt = prod_valid_r;
    prod_last_nxt  = prod_last_r;
    prod_m_nxt     = prod_m_r;
    prod_o_nxt     = prod_o_r;
    if (q_pop) begin
      prod_valid_nxt = 1'b1;
      prod_last_nxt  = q_rdata.last;
      prod_m_nxt     = $signed({1'b0, q_rdata.sq_mover}) * q_rdata.w_mover;
      prod_o_nxt     = $signed({1'b0, q_rdata.sq_opp}) * q_rdata.w_opp;
    end else if (prod_take) begin
      prod_valid_nxt = 1'b0;
    end
  end

  assign sum_full = ACC_W'(sum_r) + ACC_W'(prod_m_r) + ACC_W'(prod_o_r);

  always_comb begin
    if (sum_full > ACC_W'(SUM_MAX)) begin
      sum_sat = SUM_MAX;
    end else if (sum_full < ACC_W'(SUM_MIN)) begin
      sum_sat = SUM_MIN;
    end else begin
      sum_sat = sum_full[SUM_W-1:0];
    end
  end

  always_comb begin
    sum_nxt = sum_r;
    if (prod_take) begin
      sum_nxt = prod_last_r ? '0 : sum_sat;
    end
  end

  assign bias_nxt = cfg_wr_en ? cfg_wr_data : bias_r;

  // Finaliser next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FIN_IDLE: begin
        if (prod_take && prod_last_r) begin
          state_nxt = FIN_LAUNCH1;
        end
      end
      FIN_LAUNCH1: state_nxt = FIN_DIV1;
      FIN_DIV1: begin
        if (div_stat.done) begin
          state_nxt = FIN_BIAS;
        end
      end
      FIN_BIAS:    state_nxt = FIN_SCALE;
      FIN_SCALE:   state_nxt = FIN_LAUNCH2;
      FIN_LAUNCH2: state_nxt = FIN_DIV2;
      FIN_DIV2: begin
        if (div_stat.done) begin
          state_nxt = FIN_EMIT;
        end
      end
      FIN_EMIT: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = FIN_IDLE;
        end
      end
      default: state_nxt = FIN_IDLE;
    endcase
  end

  assign quo_signed = neg_r ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});

  // Finaliser datapath and outputs.
  always_comb begin
    fin_nxt   = fin_r;
    neg_nxt   = neg_r;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      FIN_IDLE: begin
        if (prod_take && prod_last_r) begin
          fin_nxt = FIN_W'(sum_sat);
        end
      end
      FIN_LAUNCH1, FIN_LAUNCH2: begin
        div_start = 1'b1;
        neg_nxt   = fin_r[FIN_W-1];
      end
      FIN_DIV1, FIN_DIV2: begin
        if (div_stat.done) begin
          fin_nxt = quo_signed;
        end
      end
      FIN_BIAS:  fin_nxt = fin_r + FIN_W'(bias_r);
      // Times 400 as 256 + 128 + 16.
      FIN_SCALE: fin_nxt = (fin_r <<< 8) + (fin_r <<< 7) + (fin_r <<< 4);
      FIN_EMIT:  out_load = !out_valid_r || out_tready;
      default: begin
        fin_nxt = fin_r;
      end
    endcase
  end

  assign div_num      = fin_r[FIN_W-1] ? DIV_W'(-fin_r) : DIV_W'(fin_r);
  // The second division is the one by 16320.
  assign div_by_scale = (state_r == FIN_LAUNCH2);

  always_comb begin
    if (fin_r > SCORE_MAX) begin
      score_sat = SCORE_MAX;
    end else if (fin_r < SCORE_MIN) begin
      score_sat = SCORE_MIN;
    end else begin
      score_sat = fin_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_score_nxt = out_score_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_score_nxt = score_sat[SCORE_W-1:0];
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
      sum_r        <= '0;
      state_r      <= FIN_IDLE;
      bias_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      prod_valid_r <= prod_valid_nxt;
      sum_r        <= sum_nxt;
      state_r      <= state_nxt;
      bias_r       <= bias_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_last_r <= prod_last_nxt;
    prod_m_r    <= prod_m_nxt;
    prod_o_r    <= prod_o_nxt;
    fin_r       <= fin_nxt;
    neg_r       <= neg_nxt;
    out_score_r <= out_score_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-SCORE_W){1'b0}}, out_score_r};

`ifndef SYNTHESIS
  a_last_starts_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (prod_take && prod_last_r) |=> (state_r == FIN_LAUNCH1))
    else $error("last item accumulated without starting the finaliser");
  a_last_held: assert property (@(posedge clk) disable iff (!rst_n)
    (prod_valid_r && prod_last_r && fin_busy) |=> (prod_valid_r && prod_last_r))
    else $error("last item dropped while the finaliser was busy");
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FIN_IDLE) |-> !div_stat.busy)
    else $error("divider running while the finaliser is idle");
  a_div_running: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == FIN_DIV1 || state_r == FIN_DIV2) && !div_stat.done) |-> div_stat.busy)
    else $error("finaliser waits on a divider that is not running");
`endif

endmodule

`default_nettype wire

// ===== src/screlu_output_layer_eval.sv =====
// ----------------------------------------------------------------------------
// screlu_output_layer_eval: streamed SCReLU output layer of an NNUE evaluator
// Accumulates weighted squared activations and turns the sum into a score.
// ----------------------------------------------------------------------------
// Usage. Each input beat carries one hidden index: both perspective
// accumulator elements, the mover and opponent weights, the side to move in
// in_tuser and the end of an evaluation in in_tlast. Beats without tlast give
// no result; the beat with tlast gives one score beat on the out_ channel and
// clears the running sum for the next evaluation. The user is to write the
// bias through cfg_wr_en and cfg_wr_data only while the block is idle; the
// block itself does not enforce this. Throughput is one beat per cycle as
// long as the queue has room. The time from a last beat to its score grows
// with the number of base-256 folds the divider needs in its division by 255
// and in the one by 16320, fewer for small sums.
// Beats of the next evaluation keep flowing into the queue and the
// accumulator meanwhile; only a further last beat waits for the finaliser.
// When out_tready is low the score stays in the output register and the
// finaliser holds; once a further last beat waits, the queue fills and drops
// in_tready. Reset (rst_n low, synchronous) empties the queue, clears the
// running sum and the bias, and drops out_tvalid.
// ----------------------------------------------------------------------------
`default_nettype none

module screlu_output_layer_eval #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // Bias register, signed.
  input  wire logic                               cfg_wr_en,
  input  wire logic signed [15:0]                 cfg_wr_data,
  // Input channel.
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // white_acc [15:0], black_acc [31:16], mover_weight [47:32],
  // opponent_weight [63:48]
  input  wire logic [sole_pkg::IN_TDATA_W-1:0]    in_tdata,
  // side_to_move [0]
  input  wire logic                               in_tuser,
  input  wire logic                               in_tlast,
  // Result channel.
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // score [27:0], zeros above
  output logic [sole_pkg::OUT_TDATA_W-1:0]        out_tdata
);
  import sole_pkg::*;

  q_entry_t              q_wdata;
  q_entry_t              q_rdata;
  logic                  q_push;
  logic                  q_pop;
  logic                  q_full;
  logic                  q_empty;
  logic                  div_start;
  logic [DIV_W-1:0]      div_num;
  logic                  div_by_scale;
  div_stat_t             div_stat;
  logic [DIV_W-1:0]      div_quo;

  // Front: selection, clamping and squaring of each beat.
  sole_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  // The queue lets the front keep accepting while the back is held up.
  sole_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  // Back: products, running sum and score finaliser.
  sole_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .q_empty      (q_empty),
    .q_rdata      (q_rdata),
    .q_pop        (q_pop),
    .div_start    (div_start),
    .div_num      (div_num),
    .div_by_scale (div_by_scale),
    .div_stat     (div_stat),
    .div_quo      (div_quo),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata)
  );

  // One divider serves both the division by 255 and the one by 16320.
  sole_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .num      (div_num),
    .by_scale (div_by_scale),
    .stat     (div_stat),
    .quo      (div_quo)
  );

endmodule

`default_nettype wire
